>>> design/vf_three_phase_modulator_top_defines.svh
// Assertion macros for the three-phase modulator checker.
// Depends on nothing; included by the checker file.
`ifndef VF_THREE_PHASE_MODULATOR_TOP_DEFINES_SVH
`define VF_THREE_PHASE_MODULATOR_TOP_DEFINES_SVH

// Clocked property, masked while reset is high.
`define VTPM_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define VTPM_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/vtpm_pkg.sv
// Shared constants, sine table and pipeline word types for the modulator.
// No dependencies; imported by every design module except the checker.
package vtpm_pkg;

  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int QLEN   = (SINE_TABLE_ENTRIES / 4 > 0) ? SINE_TABLE_ENTRIES / 4 : 1;
  localparam int FULL   = 4 * QLEN;
  localparam int IDX_W  = $clog2(FULL);
  localparam int QIDX_W = $clog2(QLEN + 1);

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint POLY_A1 = 64'sd1686629713;
  localparam longint POLY_A3 = 64'sd693598668;
  localparam longint POLY_A5 = 64'sd85569305;
  localparam longint POLY_A7 = 64'sd5026995;
  localparam longint POLY_A9 = 64'sd172272;

  localparam logic [15:0]        AMP_MAX        = 16'd32768;
  localparam logic signed [31:0] SQRT3_HALF_Q15 = 32'sd28378;
  localparam logic [16:0]        DUTY_CENTRE    = 17'd16384;
  localparam logic signed [50:0] ROUND_HALF     = 51'sd1073741824;

  localparam logic [0:0] REG_MODULATION_MODE = 1'b0;

  typedef logic [15:0] qtab_t [0:QLEN];

  // Quarter-wave sine in Q15: odd degree-9 polynomial in Q30, evaluated at elaboration.
  function automatic qtab_t build_qtab();
    qtab_t  t;
    longint x;
    longint x2;
    longint p;
    longint y;
    for (int r = 0; r <= QLEN; r++) begin
      x  = (longint'(r) <<< 30) / QLEN;
      x2 = (x * x) / Q30_ONE;
      p  = POLY_A9;
      p  = -POLY_A7 + (p * x2) / Q30_ONE;
      p  = POLY_A5 + (p * x2) / Q30_ONE;
      p  = -POLY_A3 + (p * x2) / Q30_ONE;
      p  = POLY_A1 + (p * x2) / Q30_ONE;
      y  = (p * x) / Q30_ONE;
      if (y < 0) y = 0;
      y = (y + 64'sd16384) >>> 15;
      if (y > 64'sd32768) y = 64'sd32768;
      t[r] = y[15:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  typedef struct packed {
    logic              neg;
    logic [QIDX_W-1:0] addr;
  } qsel_t;

  typedef struct packed {
    qsel_t       s_sel;
    qsel_t       c_sel;
    logic [15:0] amp;
  } angle_word_t;

  typedef struct packed {
    logic signed [16:0] sin_v;
    logic signed [16:0] cos_v;
    logic [15:0]        amp;
  } trig_word_t;

  typedef struct packed {
    logic signed [31:0] ka;
    logic signed [31:0] kb;
    logic signed [31:0] kc;
    logic [15:0]        amp;
  } coef_word_t;

  typedef struct packed {
    logic signed [46:0] ua;
    logic signed [46:0] vb;
    logic signed [46:0] wc;
  } phase_word_t;

  typedef struct packed {
    logic [16:0] duty_a;
    logic [16:0] duty_b;
    logic [16:0] duty_c;
  } duty_word_t;

endpackage

>>> design/vtpm_trig.sv
// Angle decode and quarter-wave sine/cosine lookup, two register stages.
// Depends on vtpm_pkg (table, widths, word types).
module vtpm_trig
  import vtpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] angle_phase,
  input  logic [15:0] amplitude,
  output logic        out_valid,
  input  logic        out_ready,
  output trig_word_t  out_word
);

  logic        v1;
  logic        v2;
  logic        rdy1;
  logic        rdy2;
  angle_word_t st1;
  angle_word_t st1_next;
  trig_word_t  st2;
  trig_word_t  st2_next;

  logic [31:0]      prod;
  logic [IDX_W-1:0] idx_s;
  logic [IDX_W:0]   idx_sum;
  logic [IDX_W-1:0] idx_c;

  // Quadrant fold: compares against Q, 2Q, 3Q so any quarter length works.
  function automatic qsel_t fold(input logic [IDX_W-1:0] i);
    qsel_t            o;
    logic [IDX_W-1:0] r;
    logic             mirror;
    if (i < IDX_W'(QLEN)) begin
      r = i; mirror = 1'b0; o.neg = 1'b0;
    end else if (i < IDX_W'(2 * QLEN)) begin
      r = i - IDX_W'(QLEN); mirror = 1'b1; o.neg = 1'b0;
    end else if (i < IDX_W'(3 * QLEN)) begin
      r = i - IDX_W'(2 * QLEN); mirror = 1'b0; o.neg = 1'b1;
    end else begin
      r = i - IDX_W'(3 * QLEN); mirror = 1'b1; o.neg = 1'b1;
    end
    o.addr = mirror ? QIDX_W'(IDX_W'(QLEN) - r) : QIDX_W'(r);
    return o;
  endfunction

  function automatic logic signed [16:0] lookup(input qsel_t sel);
    logic signed [16:0] mag;
    mag = $signed({1'b0, QTAB[sel.addr]});
    return sel.neg ? -mag : mag;
  endfunction

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    prod    = 32'(angle_phase) * 32'(FULL);
    idx_s   = prod[IDX_W+15:16];
    idx_sum = {1'b0, idx_s} + (IDX_W+1)'(QLEN);
    idx_c   = (idx_sum >= (IDX_W+1)'(FULL)) ? IDX_W'(idx_sum - (IDX_W+1)'(FULL))
                                             : idx_sum[IDX_W-1:0];
    st1_next.s_sel = fold(idx_s);
    st1_next.c_sel = fold(idx_c);
    st1_next.amp   = (amplitude > AMP_MAX) ? AMP_MAX : amplitude;
  end

  always_comb begin
    st2_next.sin_v = lookup(st1.s_sel);
    st2_next.cos_v = lookup(st1.c_sel);
    st2_next.amp   = st1.amp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) st1 <= st1_next;
    if (rdy2 && v1) st2 <= st2_next;
  end

  assign out_valid = v2;
  assign out_word  = st2;

endmodule

>>> design/vtpm_mult.sv
// Phase voltage products: constant weights, then amplitude multiply.
// Depends on vtpm_pkg (word types, sqrt(3)/2 constant).
module vtpm_mult
  import vtpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  trig_word_t  in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output phase_word_t out_word
);

  logic        v1;
  logic        v2;
  logic        rdy1;
  logic        rdy2;
  coef_word_t  st1;
  coef_word_t  st1_next;
  phase_word_t st2;
  phase_word_t st2_next;

  logic signed [31:0] s_w;
  logic signed [31:0] c_w;
  logic signed [31:0] s_k;
  logic signed [31:0] c_half;
  logic signed [16:0] amp_s;
  logic signed [48:0] pa;
  logic signed [48:0] pb;
  logic signed [48:0] pc;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s_w         = 32'(in_word.sin_v);
    c_w         = 32'(in_word.cos_v);
    s_k         = s_w * SQRT3_HALF_Q15;
    c_half      = c_w <<< 14;
    st1_next.ka = c_w <<< 15;
    st1_next.kb = s_k - c_half;
    st1_next.kc = -c_half - s_k;
    st1_next.amp = in_word.amp;
  end

  // Results stay exact: |amp| <= 2^15 and |k| < 2^31, so 47 bits hold them.
  always_comb begin
    amp_s       = $signed({1'b0, st1.amp});
    pa          = amp_s * st1.ka;
    pb          = amp_s * st1.kb;
    pc          = amp_s * st1.kc;
    st2_next.ua = pa[46:0];
    st2_next.vb = pb[46:0];
    st2_next.wc = pc[46:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) st1 <= st1_next;
    if (rdy2 && v1) st2 <= st2_next;
  end

  assign out_valid = v2;
  assign out_word  = st2;

endmodule

>>> design/vtpm_inject.sv
// Min-max zero-sequence term (zero in plain sinusoidal mode) and duty rounding, two register stages.
// Depends on vtpm_pkg (word types, rounding constants).
module vtpm_inject
  import vtpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  phase_word_t in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output duty_word_t  out_word
);

  logic               v1;
  logic               v2;
  logic               rdy1;
  logic               rdy2;
  phase_word_t        ph;
  logic signed [47:0] zs;
  logic signed [47:0] zs_next;
  duty_word_t         st2;
  duty_word_t         st2_next;

  logic signed [46:0] hi;
  logic signed [46:0] lo;

  // duty = centre + floor((2x - m + 2^30) / 2^31), low 17 bits kept
  function automatic logic [16:0] finish(input logic signed [46:0] x,
                                         input logic signed [47:0] m);
    logic signed [50:0] n;
    logic [16:0]        q;
    n = (51'(x) <<< 1) - 51'(m) + ROUND_HALF;
    q = n[47:31];
    return q + DUTY_CENTRE;
  endfunction

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    hi = in_word.ua;
    lo = in_word.ua;
    if (in_word.vb > hi) hi = in_word.vb;
    if (in_word.wc > hi) hi = in_word.wc;
    if (in_word.vb < lo) lo = in_word.vb;
    if (in_word.wc < lo) lo = in_word.wc;
    zs_next = mode ? (48'(hi) + 48'(lo)) : 48'sd0;
  end

  always_comb begin
    st2_next.duty_a = finish(ph.ua, zs);
    st2_next.duty_b = finish(ph.vb, zs);
    st2_next.duty_c = finish(ph.wc, zs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ph <= in_word;
      zs <= zs_next;
    end
    if (rdy2 && v1) st2 <= st2_next;
  end

  assign out_valid = v2;
  assign out_word  = st2;

endmodule

>>> design/vf_three_phase_modulator_top.sv
// Channel   | dir | handshake             | payload
// s_axis    | in  | s_tvalid / s_tready   | s_tdata: angle_phase, amplitude
// m_axis    | out | m_tvalid / m_tready   | m_tdata: duty_phase_a, _b, _c
// apb cfg   | in  | psel, penable, pready | modulation_mode at byte address 0
//
// One word per cycle while the output is not stalled; six register stages
// (decode, table, weights, amplitude multiply, zero-sequence term, rounding).
// Each stage holds its own valid bit and moves on when the next one is empty or
// moving, so bubbles are squeezed out during an output stall. Synchronous reset
// empties the pipeline and clears the mode register to plain sinusoidal.
//
// Depends on vtpm_pkg, vtpm_trig, vtpm_mult, vtpm_inject.
module vf_three_phase_modulator_top
  import vtpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] angle_phase, [31:16] amplitude
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [16:0] duty_phase_a, [33:17] duty_phase_b,
                                 // [50:34] duty_phase_c, [55:51] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        modulation_mode;
  logic        trig_valid;
  logic        trig_ready;
  trig_word_t  trig_word;
  logic        mult_valid;
  logic        mult_ready;
  phase_word_t mult_word;
  duty_word_t  duty_word;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulation_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODULATION_MODE) begin
      modulation_mode <= pwdata[0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODULATION_MODE: prdata = {31'b0, modulation_mode};
      default:             prdata = 32'b0;
    endcase
  end

  vtpm_trig u_trig (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .angle_phase (s_tdata[15:0]),
    .amplitude   (s_tdata[31:16]),
    .out_valid   (trig_valid),
    .out_ready   (trig_ready),
    .out_word    (trig_word)
  );

  vtpm_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_word   (trig_word),
    .out_valid (mult_valid),
    .out_ready (mult_ready),
    .out_word  (mult_word)
  );

  vtpm_inject u_inject (
    .clk       (clk),
    .rst       (rst),
    .mode      (modulation_mode),
    .in_valid  (mult_valid),
    .in_ready  (mult_ready),
    .in_word   (mult_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (duty_word)
  );

  assign m_tdata = {5'b0, duty_word.duty_c, duty_word.duty_b, duty_word.duty_a};

endmodule

>>> design/vtpm_checker.sv
// Port-level checks for the modulator, bound to the top level.
// Depends on vf_three_phase_modulator_top_defines.svh.
`include "vf_three_phase_modulator_top_defines.svh"

module vtpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // Held word stays put until taken.
  `VTPM_CHECK(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output word changed while stalled")

  // Input back-pressure only when the whole pipe is full behind a stalled output.
  `VTPM_CHECK(a_backpressure, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output stall")

  // Pipeline comes out of reset empty.
  `VTPM_CHECK_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid straight after reset")

  // Duty A stays in range and the padding stays clear.
  `VTPM_CHECK(a_duty_range, m_tvalid |-> (m_tdata[55:51] == 5'b0 && ($signed(m_tdata[16:0]) >= -17'sd16384) && ($signed(m_tdata[16:0]) <= 17'sd49152)), "duty out of range")

endmodule

bind vf_three_phase_modulator_top vtpm_checker u_vtpm_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for vf_three_phase_modulator_top: angle/amplitude words in,
// three phase duties out, predicted per word in both modulation modes.
// Needs only the RTL of the block (top, its submodules and its package).
module testbench;

  localparam int     TABLE_POINTS = 256;
  localparam int     QUARTER      = (TABLE_POINTS / 4 > 0) ? TABLE_POINTS / 4 : 1;
  localparam int     FULL_PTS     = 4 * QUARTER;
  localparam longint Q30          = 64'sd1073741824;
  localparam longint AMP_ONE      = 64'sd32768;
  localparam longint COS30_Q15    = 64'sd28378;
  localparam longint HALF_Q15     = 64'sd16384;
  localparam longint POLY [0:4]   = '{64'sd172272, -64'sd5026995, 64'sd85569305,
                                      -64'sd693598668, 64'sd1686629713};

  localparam logic [2:0] ADDR_MODE   = 3'd0;  // modulation_mode
  localparam logic [2:0] ADDR_UNUSED = 3'd4;  // no register behind it
  localparam bit         MODE_SINE   = 1'b0;
  localparam bit         MODE_SVPWM  = 1'b1;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [15:0] angle;
    logic [15:0] amp;
    logic [16:0] duty_a;
    logic [16:0] duty_b;
    logic [16:0] duty_c;
  } duty_set_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  duty_set_t duty_q[$];
  bit        mode_shadow = MODE_SINE;
  bit        tx_idle_en  = 1'b1;
  bit        rx_idle_en  = 1'b1;
  logic      rx_hold     = 1'b0;
  int        mismatches  = 0;
  int        cycle_count = 0;
  event      rx_hold_go;

  vf_three_phase_modulator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] angle_phase, [31:16] amplitude
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [16:0] duty a, [33:17] duty b, [50:34] duty c, [55:51] zero
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL vf_three_phase_modulator_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // sin(pi/2 * r/QUARTER) in Q15, Horner in Q30 with truncating products
  function automatic longint quarter_sin(int r);
    longint x;
    longint x2;
    longint acc;
    x   = (longint'(r) << 30) / QUARTER;
    x2  = (x * x) / Q30;
    acc = POLY[0];
    for (int k = 1; k < 5; k++) acc = POLY[k] + (acc * x2) / Q30;
    acc = (acc * x) / Q30;
    if (acc < 0) acc = 0;
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > AMP_ONE) acc = AMP_ONE;
    return acc;
  endfunction

  function automatic longint wave_sin(int i);
    int r;
    r = i % QUARTER;
    case ((i / QUARTER) % 4)
      0: return quarter_sin(r);
      1: return quarter_sin(QUARTER - r);
      2: return -quarter_sin(r);
      default: return -quarter_sin(QUARTER - r);
    endcase
  endfunction

  // single round-half-up step from Q45 to Q15, centred on one half
  function automatic logic [16:0] centre_duty(longint x, longint m);
    longint n;
    n = 2 * x - m + (64'sd1 << 30);
    return 17'((n >>> 31) + HALF_Q15);
  endfunction

  function automatic duty_set_t predict_duties(logic [15:0] angle, logic [15:0] amp_in,
                                               bit svm);
    duty_set_t d;
    longint    amp;
    longint    s;
    longint    c;
    longint    ua;
    longint    vb;
    longint    wc;
    longint    hi;
    longint    lo;
    longint    m;
    int        idx;
    amp = (amp_in > 16'd32768) ? AMP_ONE : longint'(amp_in);
    idx = (int'(angle) * FULL_PTS) >> 16;
    s   = wave_sin(idx);
    c   = wave_sin((idx + QUARTER) % FULL_PTS);
    ua  = amp * (c * AMP_ONE);
    vb  = amp * (-HALF_Q15 * c + COS30_Q15 * s);
    wc  = amp * (-HALF_Q15 * c - COS30_Q15 * s);
    m   = 0;
    if (svm) begin
      hi = ua;
      lo = ua;
      if (vb > hi) hi = vb;
      if (wc > hi) hi = wc;
      if (vb < lo) lo = vb;
      if (wc < lo) lo = wc;
      m = hi + lo;
    end
    d.angle  = angle;
    d.amp    = amp_in;
    d.duty_a = centre_duty(ua, m);
    d.duty_b = centre_duty(vb, m);
    d.duty_c = centre_duty(wc, m);
    return d;
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    duty_set_t exp_d;
    if (!rst && m_tvalid && m_tready) begin
      if (duty_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_tdata));
      end else begin
        exp_d = duty_q.pop_front();
        if (m_tdata[16:0] !== exp_d.duty_a || m_tdata[33:17] !== exp_d.duty_b ||
            m_tdata[50:34] !== exp_d.duty_c)
          report_mismatch($sformatf(
            "angle %h amp %h: expected a/b/c %0d %0d %0d, got %0d %0d %0d",
            exp_d.angle, exp_d.amp, $signed(exp_d.duty_a), $signed(exp_d.duty_b),
            $signed(exp_d.duty_c), $signed(m_tdata[16:0]), $signed(m_tdata[33:17]),
            $signed(m_tdata[50:34])));
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  always @(posedge clk)
    m_tready <= !rx_hold && !(rx_idle_en && $urandom_range(99) < 11);

  // long output stall, counted here while the sender keeps offering words
  always begin
    @(rx_hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ------------------------------------------------------------ shared tasks

  task automatic send_word(logic [15:0] angle, logic [15:0] amp);
    s_tvalid <= 1'b1;
    s_tdata  <= {amp, angle};
    do @(posedge clk); while (!s_tready);
    duty_q.push_back(predict_duties(angle, amp, mode_shadow));
    if (tx_idle_en && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_MODE) mode_shadow = data[0];
    @(posedge clk);
  endtask

  task automatic apb_check_mode();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MODE;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'b0, mode_shadow})
      report_mismatch($sformatf("mode read back %h, expected %0d", got, mode_shadow));
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_amp();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // ---------------------------------------------------------------- the tests

  task automatic run_directed_set();
    logic [15:0] angles [0:11] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                   16'h00FF, 16'h0100, 16'h3FFF, 16'h5555, 16'hAAAA,
                                   16'h2AAB, 16'hD555};
    logic [15:0] amps [0:11]   = '{16'd32768, 16'd32768, 16'd32768, 16'd32767, 16'd0,
                                   16'd32769, 16'd65535, 16'd1, 16'h5555, 16'hAAAA,
                                   16'd16384, 16'h7FFF};
    for (int k = 0; k < 12; k++) send_word(angles[k], amps[k]);
    drain();
  endtask

  // extremes of both fields and the quadrant boundaries, in each mode
  task automatic test_directed();
    apb_check_mode();
    run_directed_set();
    apb_write(ADDR_MODE, 32'hFFFF_FFFF);
    apb_check_mode();
    run_directed_set();
  endtask

  // unmapped address is ignored, bits above bit 0 are ignored
  task automatic test_register_map();
    apb_write(ADDR_UNUSED, 32'h0000_0000);
    apb_check_mode();
    apb_write(ADDR_MODE, 32'hFFFF_FFFE);
    apb_check_mode();
    for (int k = 0; k < 20; k++) send_word(16'($urandom), rand_amp());
    drain();
  endtask

  task automatic test_random_phases();
    bit m;
    m = MODE_SVPWM;
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(ADDR_MODE, {31'($urandom), m});
      apb_check_mode();
      for (int k = 0; k < 350; k++) send_word(16'($urandom), rand_amp());
      drain();
      m = !m;
    end
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    apb_write(ADDR_MODE, 32'($urandom));
    for (int k = 0; k < 250; k++) send_word(16'($urandom), rand_amp());
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // pipeline fills behind the stalled output and must stall its input
  task automatic test_backpressure();
    apb_write(ADDR_MODE, {31'b0, MODE_SVPWM});
    -> rx_hold_go;
    for (int k = 0; k < 60; k++) send_word(16'($urandom), rand_amp());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_map();
    test_random_phases();
    test_no_idle();
    test_backpressure();
    if (mismatches == 0)
      $display("PASS vf_three_phase_modulator_top");
    else
      $display("FAIL vf_three_phase_modulator_top");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/vtpm_pkg.sv
design/vtpm_trig.sv
design/vtpm_mult.sv
design/vtpm_inject.sv
design/vf_three_phase_modulator_top.sv
design/vtpm_checker.sv
tb/sv/testbench.sv
